/* src/ttbe_pkg.sv */
package ttbe_pkg;

  localparam int QueueDepth = 4;
  localparam logic [15:0] TolReset = 16'd7;

  // quotient bits below the overflow test, and the divider depth that follows
  localparam int DivSteps = 31;
  localparam int DivLatency = DivSteps + 3;

  localparam int ValueShift = 16;
  localparam int GradShift = 32;

  localparam logic [1:0] ActV0 = 2'd0;
  localparam logic [1:0] ActV1 = 2'd1;
  localparam logic [1:0] ActV2 = 2'd2;
  localparam logic [1:0] ActV3 = 2'd3;

  localparam logic [1:0] RegionFirst = 2'd0;
  localparam logic [1:0] RegionSecond = 2'd1;
  localparam logic [1:0] RegionBand = 2'd2;

  typedef struct packed {
    logic pair;
    logic band;
    logic gsel;
    logic [1:0] region;
    logic signed [63:0] vnum;
    logic signed [63:0] vden;
    logic signed [31:0] gnx;
    logic signed [31:0] gny;
    logic signed [63:0] gden;
    logic signed [31:0] hnx;
    logic signed [31:0] hny;
    logic signed [63:0] hden;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/ttbe_if.sv */
interface ttbe_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] vertex0_x;
  logic signed [31:0] vertex0_y;
  logic signed [31:0] vertex1_x;
  logic signed [31:0] vertex1_y;
  logic signed [31:0] vertex2_x;
  logic signed [31:0] vertex2_y;
  logic signed [31:0] vertex3_x;
  logic signed [31:0] vertex3_y;

  modport source (
    output valid, action, point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
           vertex2_x, vertex2_y, vertex3_x, vertex3_y,
    input ready
  );
  modport sink (
    input valid, action, point_x, point_y, vertex0_x, vertex0_y, vertex1_x, vertex1_y,
          vertex2_x, vertex2_y, vertex3_x, vertex3_y,
    output ready
  );
endinterface

interface ttbe_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] basis_value;
  logic signed [31:0] gradient_x;
  logic signed [31:0] gradient_y;
  logic [1:0] region;
  logic degenerate;

  modport source (
    output valid, basis_value, gradient_x, gradient_y, region, degenerate,
    input ready
  );
  modport sink (
    input valid, basis_value, gradient_x, gradient_y, region, degenerate,
    output ready
  );
endinterface

interface ttbe_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* src/ttbe_front.sv */
module ttbe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         tol,
  ttbe_in_if.sink             item,
  input  ttbe_pkg::q_stat_t   qstat,
  output logic                push,
  output ttbe_pkg::entry_t    entry
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  localparam int NumAreas = 5;
  localparam int AFlag = 0;
  localparam int ATri1 = 1;
  localparam int ATri2 = 2;
  localparam int AEdge1 = 3;
  localparam int AEdge2 = 4;

  function automatic logic signed [31:0] dsat(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'sd2147483647) return 32'sd2147483647;
    if (d < -33'sd2147483647) return -32'sd2147483647;
    return d[31:0];
  endfunction

  logic en;
  logic v1, v2, v3, v4, v5;

  logic [1:0] act1, act2, act3, act4, act5;
  pt_t p1;
  pt_t vt1 [4];

  pt_t ga, gb, ha, hb;
  pt_t ca [NumAreas];
  pt_t cb [NumAreas];
  pt_t cc [NumAreas];

  logic signed [31:0] d2 [NumAreas][4];
  pt_t gn2, gn3, gn4, gn5;
  pt_t hn2, hn3, hn4, hn5;

  logic signed [63:0] m3 [NumAreas][2];
  logic signed [63:0] ar4 [NumAreas];

  logic signed [63:0] nflag, vnum, vden, gden, barea;
  logic fneg, fpos, incl;

  logic signed [63:0] vnum5, vden5, gden5, a2_5;
  logic fneg5, fpos5, incl5, bneg5;
  logic [78:0] prod5;
  logic [63:0] fmag5;

  logic band, pair;

  // stall everything while the last stage waits on a full queue
  assign en = !(v5 && qstat.full);
  assign item.ready = en;
  assign push = v5 && !qstat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= item.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1 <= item.action;
      p1 <= {item.point_x, item.point_y};
      vt1[0] <= {item.vertex0_x, item.vertex0_y};
      vt1[1] <= {item.vertex1_x, item.vertex1_y};
      vt1[2] <= {item.vertex2_x, item.vertex2_y};
      vt1[3] <= {item.vertex3_x, item.vertex3_y};
    end
  end

  // pick the edges that this basis works with
  always_comb begin
    case (act1)
      ttbe_pkg::ActV0: begin
        ga = vt1[1]; gb = vt1[2]; ha = vt1[2]; hb = vt1[3];
      end
      ttbe_pkg::ActV1: begin
        ga = vt1[2]; gb = vt1[0]; ha = vt1[2]; hb = vt1[3];
      end
      ttbe_pkg::ActV2: begin
        ga = vt1[0]; gb = vt1[1]; ha = vt1[3]; hb = vt1[0];
      end
      default: begin
        ga = vt1[0]; gb = vt1[2]; ha = vt1[2]; hb = vt1[3];
      end
    endcase
    ca[AFlag] = p1;     cb[AFlag] = vt1[2];  cc[AFlag] = vt1[0];
    ca[ATri1] = vt1[0]; cb[ATri1] = vt1[1];  cc[ATri1] = vt1[2];
    ca[ATri2] = vt1[0]; cb[ATri2] = vt1[2];  cc[ATri2] = vt1[3];
    ca[AEdge1] = p1;    cb[AEdge1] = ga;     cc[AEdge1] = gb;
    ca[AEdge2] = p1;    cb[AEdge2] = ha;     cc[AEdge2] = hb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumAreas; k++) begin
        d2[k][0] <= dsat(cb[k].x, ca[k].x);
        d2[k][1] <= dsat(cc[k].y, ca[k].y);
        d2[k][2] <= dsat(cb[k].y, ca[k].y);
        d2[k][3] <= dsat(cc[k].x, ca[k].x);
      end
      gn2 <= {dsat(ga.y, gb.y), dsat(gb.x, ga.x)};
      hn2 <= {dsat(ha.y, hb.y), dsat(hb.x, ha.x)};
      act2 <= act1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumAreas; k++) begin
        m3[k][0] <= d2[k][0] * d2[k][1];
        m3[k][1] <= d2[k][2] * d2[k][3];
      end
      gn3 <= gn2;
      hn3 <= hn2;
      act3 <= act2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumAreas; k++) begin
        ar4[k] <= m3[k][0] - m3[k][1];
      end
      gn4 <= gn3;
      hn4 <= hn3;
      act4 <= act3;
    end
  end

  // classify against the diagonal and route numerators and divisors
  always_comb begin
    nflag = -ar4[AFlag];
    fneg = ar4[AFlag][63];
    fpos = !ar4[AFlag][63] && (ar4[AFlag] != 64'sd0);
    case (act4)
      ttbe_pkg::ActV0, ttbe_pkg::ActV2: begin
        vnum = fneg ? ar4[AEdge2] : ar4[AEdge1];
        vden = fneg ? ar4[ATri2] : ar4[ATri1];
        barea = ar4[ATri2];
        incl = 1'b0;
        gden = ar4[ATri1];
      end
      ttbe_pkg::ActV1: begin
        vnum = fneg ? 64'sd0 : ar4[AFlag];
        vden = ar4[ATri1];
        barea = ar4[ATri1];
        incl = 1'b1;
        gden = ar4[ATri1];
      end
      default: begin
        vnum = fpos ? 64'sd0 : nflag;
        vden = ar4[ATri2];
        barea = ar4[ATri2];
        incl = 1'b0;
        gden = ar4[ATri2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vnum5 <= vnum;
      vden5 <= vden;
      gden5 <= gden;
      a2_5 <= ar4[ATri2];
      fneg5 <= fneg;
      fpos5 <= fpos;
      incl5 <= incl;
      bneg5 <= barea[63];
      prod5 <= 79'(barea[62:0]) * 79'(tol);
      fmag5 <= fneg ? 64'(nflag) : 64'(ar4[AFlag]);
      gn5 <= gn4;
      hn5 <= hn4;
      act5 <= act4;
    end
  end

  always_comb begin
    band = !bneg5 && (incl5 ? ({1'b0, prod5[78:16]} >= fmag5)
                            : ({fmag5, 16'h0000} < {1'b0, prod5}));
    pair = (act5 == ttbe_pkg::ActV0) || (act5 == ttbe_pkg::ActV2);
    entry.pair = pair;
    entry.band = band;
    entry.gsel = (!pair && act5 == ttbe_pkg::ActV1) ? fneg5 : fpos5;
    entry.region = band ? ttbe_pkg::RegionBand
                        : (fneg5 ? ttbe_pkg::RegionSecond : ttbe_pkg::RegionFirst);
    entry.vnum = vnum5;
    entry.vden = vden5;
    entry.gnx = gn5.x;
    entry.gny = gn5.y;
    entry.gden = gden5;
    entry.hnx = hn5.x;
    entry.hny = hn5.y;
    entry.hden = a2_5;
  end

endmodule

/* src/ttbe_queue.sv */
module ttbe_queue #(
  parameter int DEPTH = ttbe_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ttbe_pkg::entry_t   wdata,
  input  logic               pop,
  output ttbe_pkg::entry_t   rdata,
  output ttbe_pkg::q_stat_t  stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ttbe_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata = mem[rptr];
  assign stat.full = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

/* src/ttbe_div.sv */
module ttbe_div #(
  parameter int SHIFT = ttbe_pkg::ValueShift
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic signed [31:0] quo,
  output logic               zero
);

  localparam int Steps = ttbe_pkg::DivSteps;
  localparam int NW = 64 + SHIFT;
  localparam int RW = NW - Steps;
  localparam int CW = (RW > 64) ? RW : 64;
  localparam logic signed [31:0] QMax = 32'sh7FFFFFFF;
  localparam logic signed [31:0] QMin = 32'sh80000000;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
    logic npos;
    logic nneg;
  } flg_t;

  logic [63:0] na, da;
  flg_t fa;

  logic [NW-1:0] wide;
  logic [RW-1:0] r0;
  logic ovf0;

  logic [63:0] rs [Steps];
  logic [63:0] ds [Steps];
  logic [Steps-1:0] lo [Steps];
  logic [Steps-1:0] qs [Steps+1];
  flg_t fs [Steps+1];

  always_ff @(posedge clk) begin
    if (en) begin
      na <= num[63] ? 64'(-num) : 64'(num);
      da <= den[63] ? 64'(-den) : 64'(den);
      fa.neg <= num[63] ^ den[63];
      fa.zero <= (den == 64'sd0);
      fa.ovf <= 1'b0;
      fa.npos <= !num[63] && (num != 64'sd0);
      fa.nneg <= num[63];
    end
  end

  // everything above the last Steps bits must stay below the divisor
  always_comb begin
    wide = {na, {SHIFT{1'b0}}};
    r0 = wide[NW-1:Steps];
    ovf0 = CW'(r0) >= CW'(da);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs[0] <= ovf0 ? '0 : 64'(r0);
      ds[0] <= da;
      lo[0] <= wide[Steps-1:0];
      qs[0] <= '0;
      fs[0] <= '{neg: fa.neg, zero: fa.zero, ovf: ovf0, npos: fa.npos, nneg: fa.nneg};
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [64:0] t;
    logic ge;
    assign t = {rs[s], lo[s][Steps-1]};
    assign ge = t >= {1'b0, ds[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        qs[s+1] <= {qs[s][Steps-2:0], ge};
        fs[s+1] <= fs[s];
      end
    end
    if (s < Steps - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rs[s+1] <= ge ? 64'(t - {1'b0, ds[s]}) : t[63:0];
          ds[s+1] <= ds[s];
          lo[s+1] <= lo[s] << 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero <= fs[Steps].zero;
      if (fs[Steps].zero) begin
        quo <= fs[Steps].npos ? QMax : (fs[Steps].nneg ? QMin : 32'sd0);
      end else if (fs[Steps].ovf) begin
        quo <= fs[Steps].neg ? QMin : QMax;
      end else begin
        quo <= fs[Steps].neg ? -$signed({1'b0, qs[Steps]}) : $signed({1'b0, qs[Steps]});
      end
    end
  end

endmodule

/* src/ttbe_back.sv */
module ttbe_back (
  input  logic               clk,
  input  logic               rst,
  input  ttbe_pkg::entry_t   entry,
  input  ttbe_pkg::q_stat_t  qstat,
  output logic               pop,
  ttbe_out_if.source         result
);

  localparam int Lat = ttbe_pkg::DivLatency;

  typedef struct packed {
    logic pair;
    logic band;
    logic gsel;
    logic [1:0] region;
  } ctl_t;

  function automatic logic signed [31:0] half(input logic signed [32:0] s);
    logic signed [32:0] t;
    t = s + (s[32] ? 33'sd1 : 33'sd0);
    return t[32:1];
  endfunction

  logic en, ovalid;
  logic vline [Lat];
  ctl_t cline [Lat];
  ctl_t c;

  logic signed [31:0] vq, gxq, gyq, hxq, hyq;
  logic vz, gz, gyz, hz, hyz;
  logic signed [31:0] gx, gy;
  logic deg;

  assign en = !ovalid || result.ready;
  assign pop = en && !qstat.empty;
  assign result.valid = ovalid;

  ttbe_div #(.SHIFT(ttbe_pkg::ValueShift)) u_vdiv (
    .clk(clk), .en(en), .num(entry.vnum), .den(entry.vden), .quo(vq), .zero(vz)
  );
  ttbe_div #(.SHIFT(ttbe_pkg::GradShift)) u_gxdiv (
    .clk(clk), .en(en), .num(64'(entry.gnx)), .den(entry.gden), .quo(gxq), .zero(gz)
  );
  ttbe_div #(.SHIFT(ttbe_pkg::GradShift)) u_gydiv (
    .clk(clk), .en(en), .num(64'(entry.gny)), .den(entry.gden), .quo(gyq), .zero(gyz)
  );
  ttbe_div #(.SHIFT(ttbe_pkg::GradShift)) u_hxdiv (
    .clk(clk), .en(en), .num(64'(entry.hnx)), .den(entry.hden), .quo(hxq), .zero(hz)
  );
  ttbe_div #(.SHIFT(ttbe_pkg::GradShift)) u_hydiv (
    .clk(clk), .en(en), .num(64'(entry.hny)), .den(entry.hden), .quo(hyq), .zero(hyz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Lat; i++) vline[i] <= 1'b0;
      ovalid <= 1'b0;
    end else if (en) begin
      vline[0] <= pop;
      for (int i = 1; i < Lat; i++) vline[i] <= vline[i-1];
      ovalid <= vline[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cline[0] <= '{pair: entry.pair, band: entry.band, gsel: entry.gsel,
                    region: entry.region};
      for (int i = 1; i < Lat; i++) cline[i] <= cline[i-1];
    end
  end

  // average or select the two triangle gradients, or halve or clip the single one
  always_comb begin
    c = cline[Lat-1];
    if (c.pair) begin
      if (c.band) begin
        gx = half(33'(gxq) + 33'(hxq));
        gy = half(33'(gyq) + 33'(hyq));
        deg = vz | gz | gyz | hz | hyz;
      end else if (c.gsel) begin
        gx = gxq;
        gy = gyq;
        deg = vz | gz | gyz;
      end else begin
        gx = hxq;
        gy = hyq;
        deg = vz | hz | hyz;
      end
    end else begin
      deg = vz | gz | gyz;
      if (c.band) begin
        gx = half(33'(gxq));
        gy = half(33'(gyq));
      end else if (c.gsel) begin
        gx = 32'sd0;
        gy = 32'sd0;
      end else begin
        gx = gxq;
        gy = gyq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.basis_value <= vq;
      result.gradient_x <= gx;
      result.gradient_y <= gy;
      result.region <= c.region;
      result.degenerate <= deg;
    end
  end

endmodule

/* src/twin_triangle_basis_eval.sv */
// channel  | role   | request carries
// item     | sink   | action, point_x/y, vertex0..3_x/y
// cfg      | sink   | data: edge tolerance, Q0.16
// result   | source | basis_value, gradient_x/y, region, degenerate
//
// One item per cycle sustained while the result side is ready. Results pass
// through five front stages (input, differences, products, areas, band
// product), the queue, and the restoring dividers, which retire one quotient
// bit per stage, before the result register.
// Reset clears valid flags and queue pointers; tolerance returns to 7.
// A stalled result freezes the divider pipeline; the front keeps running
// until the queue fills, then item.ready drops.
module twin_triangle_basis_eval #(
  parameter int QUEUE_DEPTH = ttbe_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  ttbe_in_if.sink    item,
  ttbe_cfg_if.sink   cfg,
  ttbe_out_if.source result
);

  logic [15:0] tol;
  logic push, pop;
  ttbe_pkg::entry_t wentry, rentry;
  ttbe_pkg::q_stat_t qstat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= ttbe_pkg::TolReset;
    end else if (cfg.valid) begin
      tol <= cfg.data;
    end
  end

  ttbe_front u_front (
    .clk(clk), .rst(rst), .tol(tol), .item(item), .qstat(qstat),
    .push(push), .entry(wentry)
  );

  ttbe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(wentry), .pop(pop),
    .rdata(rentry), .stat(qstat)
  );

  ttbe_back u_back (
    .clk(clk), .rst(rst), .entry(rentry), .qstat(qstat), .pop(pop),
    .result(result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty) else $error("queue read while empty");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !pop) else $error("pop during output stall");

endmodule

/* dv/ttbe_tb_if.sv */
`timescale 1ns / 100ps

// Local copies of the channel bundles are not needed; the RTL interfaces are used directly.
// This file keeps small helpers shared by the bench.
package ttbe_tb_pkg;

  typedef struct {
    logic [1:0] action;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx [4];
    logic signed [31:0] vy [4];
  } point_req_t;

  typedef struct {
    logic signed [31:0] basis_value;
    logic signed [31:0] gradient_x;
    logic signed [31:0] gradient_y;
    logic [1:0] region;
    logic degenerate;
  } basis_res_t;

endpackage

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ttbe_pkg::*;
  import ttbe_tb_pkg::*;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam int Latency = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ttbe_in_if item ();
  ttbe_cfg_if cfg ();
  ttbe_out_if result ();

  twin_triangle_basis_eval dut (
    .clk(clk), .rst(rst), .item(item.sink), .cfg(cfg.sink), .result(result.source)
  );

  always #6 clk = ~clk;

  logic [15:0] tolerance = TolReset;
  basis_res_t expected_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;

  initial begin
    item.valid = 1'b0;
    item.action = '0;
    item.point_x = '0;
    item.point_y = '0;
    item.vertex0_x = '0;
    item.vertex0_y = '0;
    item.vertex1_x = '0;
    item.vertex1_y = '0;
    item.vertex2_x = '0;
    item.vertex2_y = '0;
    item.vertex3_x = '0;
    item.vertex3_y = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    result.ready = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint diff_sat(longint a, longint b);
    longint d;
    d = a - b;
    if (d > QMax) d = QMax;
    if (d < -QMax) d = -QMax;
    return d;
  endfunction

  function automatic longint tri_area(longint ax, longint ay, longint bx, longint by,
                                      longint cx, longint cy);
    return diff_sat(bx, ax) * diff_sat(cy, ay) - diff_sat(by, ay) * diff_sat(cx, ax);
  endfunction

  function automatic longint fixed_quot(longint num, longint den, int sh, ref bit deg);
    logic [63:0] n, d, q, r, res;
    bit neg;
    if (den == 0) begin
      deg = 1'b1;
      return num > 0 ? QMax : (num < 0 ? QMin : 0);
    end
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    neg = (num < 0) != (den < 0);
    q = n / d;
    r = n % d;
    if (q != 0 && (sh >= 31 || q >= (64'd1 << (31 - sh)))) return neg ? QMin : QMax;
    res = q;
    for (int i = 0; i < sh; i++) begin
      r = r << 1;
      res = res << 1;
      if (r >= d) begin
        r = r - d;
        res[0] = 1'b1;
      end
    end
    if (res >= (64'd1 << 31)) return neg ? QMin : QMax;
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic bit near_diagonal(longint flag, longint area, bit inclusive);
    logic [63:0] a, f, fl, lo;
    if (area < 0) return 1'b0;
    a = area;
    f = flag < 0 ? -flag : flag;
    lo = (a & 64'hFFFF) * tolerance;
    fl = (a >> 16) * tolerance + (lo >> 16);
    if (inclusive) return f <= fl;
    return f < fl || (f == fl && lo[15:0] != 0);
  endfunction

  function automatic void edge_normal(output longint gx, output longint gy, input longint ax,
                                      input longint ay, input longint bx, input longint by,
                                      input longint area, ref bit deg);
    gx = fixed_quot(diff_sat(ay, by), area, GradShift, deg);
    gy = fixed_quot(diff_sat(bx, ax), area, GradShift, deg);
  endfunction

  function automatic basis_res_t eval_basis(point_req_t q);
    basis_res_t r;
    longint px, py, vx [4], vy [4], flag, a1, a2, f4, val, gx, gy, hx, hy;
    bit deg, band;
    int e1a, e1b, e2a, e2b;
    deg = 0;
    band = 0;
    px = q.px;
    py = q.py;
    for (int k = 0; k < 4; k++) begin
      vx[k] = q.vx[k];
      vy[k] = q.vy[k];
    end
    flag = tri_area(px, py, vx[2], vy[2], vx[0], vy[0]);
    a1 = tri_area(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
    a2 = tri_area(vx[0], vy[0], vx[2], vy[2], vx[3], vy[3]);
    if (q.action == ActV0 || q.action == ActV2) begin
      e1a = q.action == ActV0 ? 1 : 0;
      e1b = q.action == ActV0 ? 2 : 1;
      e2a = q.action == ActV0 ? 2 : 3;
      e2b = q.action == ActV0 ? 3 : 0;
      if (flag >= 0)
        val = fixed_quot(tri_area(px, py, vx[e1a], vy[e1a], vx[e1b], vy[e1b]), a1,
                         ValueShift, deg);
      else
        val = fixed_quot(tri_area(px, py, vx[e2a], vy[e2a], vx[e2b], vy[e2b]), a2,
                         ValueShift, deg);
      if (near_diagonal(flag, a2, 0)) begin
        band = 1;
        edge_normal(gx, gy, vx[e1a], vy[e1a], vx[e1b], vy[e1b], a1, deg);
        edge_normal(hx, hy, vx[e2a], vy[e2a], vx[e2b], vy[e2b], a2, deg);
        gx = (gx + hx) / 2;
        gy = (gy + hy) / 2;
      end else if (flag > 0) begin
        edge_normal(gx, gy, vx[e1a], vy[e1a], vx[e1b], vy[e1b], a1, deg);
      end else begin
        edge_normal(gx, gy, vx[e2a], vy[e2a], vx[e2b], vy[e2b], a2, deg);
      end
    end else if (q.action == ActV1) begin
      val = fixed_quot(flag < 0 ? 0 : flag, a1, ValueShift, deg);
      edge_normal(gx, gy, vx[2], vy[2], vx[0], vy[0], a1, deg);
      if (near_diagonal(flag, a1, 1)) begin
        band = 1;
        gx = gx / 2;
        gy = gy / 2;
      end else if (flag < 0) begin
        gx = 0;
        gy = 0;
      end
    end else begin
      f4 = tri_area(px, py, vx[0], vy[0], vx[2], vy[2]);
      val = fixed_quot(f4 < 0 ? 0 : f4, a2, ValueShift, deg);
      edge_normal(gx, gy, vx[0], vy[0], vx[2], vy[2], a2, deg);
      if (near_diagonal(f4, a2, 0)) begin
        band = 1;
        gx = gx / 2;
        gy = gy / 2;
      end else if (f4 < 0) begin
        gx = 0;
        gy = 0;
      end
    end
    r.basis_value = val[31:0];
    r.gradient_x = gx[31:0];
    r.gradient_y = gy[31:0];
    r.region = band ? RegionBand : (flag >= 0 ? RegionFirst : RegionSecond);
    r.degenerate = deg;
    return r;
  endfunction

  // ---------------- drivers ----------------
  // valid stays high after acceptance so the next request can follow at once;
  // drop it only when idling or at the end of a sequence
  task automatic send_point(point_req_t q);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item.valid <= 1'b0;
      do @(posedge clk); while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
    end
    item.valid <= 1'b1;
    item.action <= q.action;
    item.point_x <= q.px;
    item.point_y <= q.py;
    item.vertex0_x <= q.vx[0];
    item.vertex0_y <= q.vy[0];
    item.vertex1_x <= q.vx[1];
    item.vertex1_y <= q.vy[1];
    item.vertex2_x <= q.vx[2];
    item.vertex2_y <= q.vy[2];
    item.vertex3_x <= q.vx[3];
    item.vertex3_y <= q.vy[3];
    do @(posedge clk); while (!item.ready);
    expected_results.push_back(eval_basis(q));
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] value);
    drain();
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    tolerance = value;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result.ready <= 1'b0;
    end else begin
      result.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    basis_res_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result value=%h", result.basis_value);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (result.basis_value !== e.basis_value) begin
          $error("basis_value expected %h actual %h", e.basis_value, result.basis_value);
          errors++;
        end
        if (result.gradient_x !== e.gradient_x) begin
          $error("gradient_x expected %h actual %h", e.gradient_x, result.gradient_x);
          errors++;
        end
        if (result.gradient_y !== e.gradient_y) begin
          $error("gradient_y expected %h actual %h", e.gradient_y, result.gradient_y);
          errors++;
        end
        if (result.region !== e.region) begin
          $error("region expected %0d actual %0d", e.region, result.region);
          errors++;
        end
        if (result.degenerate !== e.degenerate) begin
          $error("degenerate expected %0d actual %0d", e.degenerate, result.degenerate);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
      default: return $signed($urandom_range(0, 32'h0640_0000)) - 32'sh0320_0000;
    endcase
  endfunction

  // Build a convex-ish quad around the origin, scaled randomly; in mode 1 all corners and the point are random.
  function automatic point_req_t rand_quad_point(int mode);
    point_req_t q;
    int s;
    q.action = 2'($urandom_range(3));
    s = $urandom_range(1, 2000) << $urandom_range(0, 10);
    q.vx[0] = -s; q.vy[0] = -s;
    q.vx[1] = s;  q.vy[1] = -s;
    q.vx[2] = s;  q.vy[2] = s;
    q.vx[3] = -s; q.vy[3] = s;
    for (int k = 0; k < 4; k++) begin
      q.vx[k] += $signed($urandom_range(0, s)) - s / 2;
      q.vy[k] += $signed($urandom_range(0, s)) - s / 2;
    end
    if ($urandom_range(3) == 0) begin
      // land near the diagonal
      int t;
      t = $urandom_range(0, 256);
      q.px = 32'(q.vx[0] + ((longint'(q.vx[2]) - q.vx[0]) * t >>> 8)
                 + $signed($urandom_range(0, 4)) - 2);
      q.py = 32'(q.vy[0] + ((longint'(q.vy[2]) - q.vy[0]) * t >>> 8)
                 + $signed($urandom_range(0, 4)) - 2);
    end else begin
      q.px = $signed($urandom_range(0, 4 * s)) - 2 * s;
      q.py = $signed($urandom_range(0, 4 * s)) - 2 * s;
    end
    if (mode == 1) begin
      for (int k = 0; k < 4; k++) begin
        q.vx[k] = rand_coord($urandom_range(2));
        q.vy[k] = rand_coord($urandom_range(2));
      end
      q.px = rand_coord($urandom_range(2));
      q.py = rand_coord($urandom_range(2));
    end
    return q;
  endfunction

  task automatic test_directed();
    point_req_t q;
    logic signed [31:0] ext [4] = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0, -32'sh1};
    for (int a = 0; a < 4; a++) begin
      // unit square, point inside first triangle, second triangle and on diagonal
      for (int p = 0; p < 3; p++) begin
        q.action = a[1:0];
        q.vx = '{0, 32'h10000, 32'h10000, 0};
        q.vy = '{0, 0, 32'h10000, 32'h10000};
        q.px = p == 0 ? 32'hC000 : (p == 1 ? 32'h4000 : 32'h8000);
        q.py = p == 0 ? 32'h4000 : (p == 1 ? 32'hC000 : 32'h8000);
        send_point(q);
      end
    end
    // degenerate: all corners coincide
    q.vx = '{default: 32'h1234};
    q.vy = '{default: 32'h1234};
    for (int a = 0; a < 4; a++) begin
      q.action = a[1:0];
      q.px = a[0] ? 32'h5000 : 32'h1234;
      q.py = a[1] ? -32'sh5000 : 32'h1234;
      send_point(q);
    end
    // coordinate extremes, saturating differences and quotients
    for (int i = 0; i < 4; i++) begin
      q.action = i[1:0];
      q.px = ext[i];
      q.py = ext[3 - i];
      for (int k = 0; k < 4; k++) begin
        q.vx[k] = ext[(i + k) % 4];
        q.vy[k] = ext[(i + 2 * k + 1) % 4];
      end
      send_point(q);
    end
    item.valid <= 1'b0;
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_point(rand_quad_point($urandom_range(9) == 0));
    item.valid <= 1'b0;
  endtask

  task automatic test_backpressure();
    // hold the result side long enough that the block fills and stalls its input
    hold_off <= 200;
    test_random(60);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_tolerance(16'd0);
    test_directed();
    write_tolerance(16'hFFFF);
    test_directed();
    test_random(150);
    write_tolerance(16'd7);
    test_backpressure();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 72 : 0;
      stall_pct = ph == 2 ? 72 : (ph == 3 ? 9 : 0);
      if (ph == 3) send_idle_pct = 9;
      write_tolerance(16'($urandom_range(0, 65535)));
      test_random(200);
    end
    send_idle_pct = 0;
    stall_pct = 0;
    write_tolerance(16'd300);
    test_random(100);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
src/ttbe_pkg.sv
src/ttbe_if.sv
src/ttbe_front.sv
src/ttbe_queue.sv
src/ttbe_div.sv
src/ttbe_back.sv
src/twin_triangle_basis_eval.sv
dv/ttbe_tb_if.sv
dv/testbench.sv
